// ----- rtl/kchr_pkg.sv -----
`default_nettype none

package kchr_pkg;

    // Number of keys in the combination, one or two.
    localparam int KCHR_NUM_KEYS = 2;

    // Field widths.
    localparam int KEY_CODE_W = 10;
    localparam int HOLD_W     = 24;
    localparam int LINE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_CODE_A  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_CODE_B  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_VALID  = 3'd5;

    // Configuration reset values.
    localparam logic                  RST_ENABLE     = 1'b1;
    localparam logic [KEY_CODE_W-1:0] RST_KEY_CODE_A = 10'd116;
    localparam logic [KEY_CODE_W-1:0] RST_KEY_CODE_B = 10'd114;
    localparam logic [HOLD_W-1:0]     RST_HOLD_TICKS = 24'd6000;
    localparam logic [LINE_W-1:0]     RST_ACTIVE_LOW = 2'b00;
    localparam logic [LINE_W-1:0]     RST_LINE_VALID = 2'b11;

    // Item kinds.
    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Expiry status codes.
    localparam logic [1:0] EXP_NONE     = 2'd0;
    localparam logic [1:0] EXP_FIRED    = 2'd1;
    localparam logic [1:0] EXP_NOT_HELD = 2'd2;

    // Input word.
    typedef struct packed {
        logic                  kind;
        logic [KEY_CODE_W-1:0] event_key;
        logic                  key_down;
        logic [LINE_W-1:0]     line_levels;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic              handled;
        logic [LINE_W-1:0] held_mask;
        logic              countdown_running;
        logic [1:0]        expiry_status;
        logic              reset_occurred;
    } t_out_word;

    // Configuration settings handed to the detector core.
    typedef struct packed {
        logic                  enable;
        logic [KEY_CODE_W-1:0] key_code_a;
        logic [KEY_CODE_W-1:0] key_code_b;
        logic [HOLD_W-1:0]     hold_ticks;
        logic [LINE_W-1:0]     active_low_mask;
        logic [LINE_W-1:0]     line_valid_mask;
    } t_cfg;

endpackage

`default_nettype wire

// ----- rtl/kchr_cfg_regs.sv -----
`default_nettype none

module kchr_cfg_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_wr_en,
    input  wire logic [kchr_pkg::CFG_IDX_W-1:0]    i_wr_index,
    input  wire logic [kchr_pkg::CFG_DATA_W-1:0]   i_wr_data,
    output kchr_pkg::t_cfg                         o_cfg
);
    import kchr_pkg::*;

    t_cfg r_cfg;

    // Register file, written one register per accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable          <= RST_ENABLE;
            r_cfg.key_code_a      <= RST_KEY_CODE_A;
            r_cfg.key_code_b      <= RST_KEY_CODE_B;
            r_cfg.hold_ticks      <= RST_HOLD_TICKS;
            r_cfg.active_low_mask <= RST_ACTIVE_LOW;
            r_cfg.line_valid_mask <= RST_LINE_VALID;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                CFG_ENABLE:     r_cfg.enable          <= i_wr_data[0];
                CFG_KEY_CODE_A: r_cfg.key_code_a      <= i_wr_data[KEY_CODE_W-1:0];
                CFG_KEY_CODE_B: r_cfg.key_code_b      <= i_wr_data[KEY_CODE_W-1:0];
                CFG_HOLD_TICKS: r_cfg.hold_ticks      <= i_wr_data[HOLD_W-1:0];
                CFG_ACTIVE_LOW: r_cfg.active_low_mask <= i_wr_data[LINE_W-1:0];
                CFG_LINE_VALID: r_cfg.line_valid_mask <= i_wr_data[LINE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- rtl/kchr_core.sv -----
`default_nettype none

module kchr_core #(
    parameter int NUM_KEYS = kchr_pkg::KCHR_NUM_KEYS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire kchr_pkg::t_cfg      i_cfg,
    input  wire logic                i_advance,
    input  wire kchr_pkg::t_in_word  i_word,
    output kchr_pkg::t_out_word      o_result
);
    import kchr_pkg::*;

    // Bits of held_mask that belong to configured keys.
    localparam logic [LINE_W-1:0] FULL_MASK = LINE_W'((1 << NUM_KEYS) - 1);

    logic [LINE_W-1:0] r_held;
    logic [HOLD_W-1:0] r_countdown;
    logic              r_running;
    logic              r_fired;

    logic [LINE_W-1:0] n_held;
    logic [HOLD_W-1:0] n_countdown;
    logic              n_running;
    logic              n_fired;

    logic [LINE_W-1:0] match;
    logic [LINE_W-1:0] pressed;
    logic [HOLD_W-1:0] reload;
    logic              handled;
    logic [1:0]        status;

    // Which combination keys the event code names.
    assign match[0] = (i_word.event_key == i_cfg.key_code_a);
    assign match[1] = (NUM_KEYS >= 2) && (i_word.event_key == i_cfg.key_code_b);

    // Keys that read as pressed on their sense lines.
    assign pressed = (i_word.line_levels ^ i_cfg.active_low_mask)
                   & i_cfg.line_valid_mask & FULL_MASK;

    // A zero hold time behaves as one tick.
    assign reload = (i_cfg.hold_ticks == '0) ? HOLD_W'(1) : i_cfg.hold_ticks;

    // Next state and result for the word in the input register.
    always_comb begin
        n_held      = r_held;
        n_countdown = r_countdown;
        n_running   = r_running;
        n_fired     = r_fired;
        handled     = 1'b0;
        status      = EXP_NONE;
        if (i_word.kind == KIND_KEY) begin
            if (i_cfg.enable && (match != '0)) begin
                handled = 1'b1;
                if (i_word.key_down) begin
                    n_held = (r_held | match) & FULL_MASK;
                end else begin
                    n_held = r_held & ~match & FULL_MASK;
                end
                if (n_held == FULL_MASK) begin
                    n_countdown = reload;
                    n_running   = 1'b1;
                end else begin
                    n_running   = 1'b0;
                end
            end
        end else if (r_running) begin
            if (r_countdown > HOLD_W'(1)) begin
                n_countdown = r_countdown - HOLD_W'(1);
            end else begin
                n_countdown = '0;
                n_running   = 1'b0;
                if (pressed == FULL_MASK) begin
                    n_fired = 1'b1;
                    status  = EXP_FIRED;
                end else begin
                    status  = EXP_NOT_HELD;
                end
            end
        end
    end

    // Detector state, updated once per processed word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_countdown <= '0;
            r_running   <= 1'b0;
            r_fired     <= 1'b0;
        end else if (i_advance) begin
            r_held      <= n_held;
            r_countdown <= n_countdown;
            r_running   <= n_running;
            r_fired     <= n_fired;
        end
    end

    assign o_result.handled           = handled;
    assign o_result.held_mask         = n_held;
    assign o_result.countdown_running = n_running;
    assign o_result.expiry_status     = status;
    assign o_result.reset_occurred    = n_fired;

endmodule

`default_nettype wire

// ----- rtl/key_combo_hold_reset.sv -----
`default_nettype none

// Long-press key combination reset detector. Key events that match one of the
// configured key codes set or clear that key's held bit; while every key is
// held the hold countdown is reloaded, and tick words count it down. At expiry
// the raw sense lines are checked and, if all keys still read as pressed, the
// reset_occurred flag latches until reset. Every input word gives exactly one
// result word. A word is registered on entry in the input register and its result
// in the output register; one word is taken every cycle while the output does not
// stall, a rate set by the held bits and countdown being updated once per word.
// Configuration writes are always ready and take effect on the next cycle.
module key_combo_hold_reset #(
    parameter int NUM_KEYS = kchr_pkg::KCHR_NUM_KEYS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire kchr_pkg::t_in_word              i_in_word,
    output logic                                 o_in_stall,
    output logic                                 o_out_valid,
    output kchr_pkg::t_out_word                  o_out_word,
    input  wire logic                            i_out_stall,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [kchr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [kchr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import kchr_pkg::*;

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_cfg      cfg;
    t_out_word result;
    logic      advance;
    logic      in_take;

    // The registered word moves on when the output register is free or drains.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_cfg_ready = 1'b1;

    kchr_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    kchr_core #(
        .NUM_KEYS (NUM_KEYS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_advance (advance),
        .i_word    (r_in_word),
        .o_result  (result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

// ----- rtl/kchr_checker.sv -----
`default_nettype none

module kchr_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_out_valid,
    input wire kchr_pkg::t_out_word o_out_word,
    input wire logic                i_out_stall
);
    import kchr_pkg::*;

    // A stalled result word stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // A fired expiry latches the flag and stops the countdown.
    a_fire_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.expiry_status == EXP_FIRED)
        |-> o_out_word.reset_occurred && !o_out_word.countdown_running)
        else $error("fired expiry without latched flag or with running countdown");

    // Once fired, every later result keeps the flag.
    a_fire_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out_word.reset_occurred
        |=> !o_out_valid || o_out_word.reset_occurred)
        else $error("reset_occurred flag dropped");

    // A handled key event never reports an expiry.
    a_handled_no_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.handled |-> o_out_word.expiry_status == EXP_NONE)
        else $error("handled key event reported an expiry");

endmodule

bind key_combo_hold_reset kchr_checker u_kchr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .o_out_word  (o_out_word),
    .i_out_stall (i_out_stall)
);

`default_nettype wire

// ----- tb/key_combo_hold_reset_check.sv -----
module key_combo_hold_reset_check
    import kchr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_word              i_in_word,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_word             i_out_word,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Mirror of the detector's settings, tracked from the write channel.
    logic                  set_enable;
    logic [KEY_CODE_W-1:0] set_code_a;
    logic [KEY_CODE_W-1:0] set_code_b;
    logic [HOLD_W-1:0]     set_hold;
    logic [LINE_W-1:0]     set_active_low;
    logic [LINE_W-1:0]     set_line_valid;

    // Mirror of the detector's own state.
    logic [LINE_W-1:0]     keys_held;
    logic [HOLD_W-1:0]     hold_left;
    logic                  hold_running;
    logic                  reset_fired;

    t_out_word combo_status_q[$];
    int        fail_total;
    int        status_left;

    assign o_fail_count = fail_total;
    assign o_pending    = status_left;

    // Applies one input word to the mirrored state and returns the result word it gives.
    function automatic t_out_word advance_combo(t_in_word w);
        logic [LINE_W-1:0] all_keys;
        logic [LINE_W-1:0] hit;
        logic [LINE_W-1:0] pressed;
        t_out_word         r;
        all_keys = (KCHR_NUM_KEYS >= 2) ? 2'b11 : 2'b01;
        r = '0;
        r.expiry_status = EXP_NONE;
        if (w.kind == KIND_KEY) begin
            hit = '0;
            if (w.event_key == set_code_a) hit[0] = 1'b1;
            if (KCHR_NUM_KEYS >= 2 && w.event_key == set_code_b) hit[1] = 1'b1;
            if (set_enable && hit != '0) begin
                r.handled = 1'b1;
                if (w.key_down) begin
                    keys_held = keys_held | hit;
                end else begin
                    keys_held = keys_held & ~hit & all_keys;
                end
                keys_held = keys_held & all_keys;
                // A full set of held keys restarts the hold time on every event.
                if (keys_held == all_keys) begin
                    hold_left = (set_hold != '0) ? set_hold : 24'd1;
                    hold_running = 1'b1;
                end else begin
                    hold_running = 1'b0;
                end
            end
        end else if (hold_running) begin
            if (hold_left > 24'd1) begin
                hold_left = hold_left - 24'd1;
            end else begin
                // Expiry: every key must still read as pressed on a line that exists.
                pressed = (w.line_levels ^ set_active_low) & set_line_valid & all_keys;
                hold_left = '0;
                hold_running = 1'b0;
                if (pressed == all_keys) begin
                    reset_fired = 1'b1;
                    r.expiry_status = EXP_FIRED;
                end else begin
                    r.expiry_status = EXP_NOT_HELD;
                end
            end
        end
        r.held_mask = keys_held;
        r.countdown_running = hold_running;
        r.reset_occurred = reset_fired;
        return r;
    endfunction

    // Counts a failure and reports it while the report budget lasts.
    task automatic flag_field(input string name, input int want, input int got);
        fail_total++;
        if (fail_total <= 10) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        t_out_word got;
        if (!i_rst_n) begin
            set_enable     = RST_ENABLE;
            set_code_a     = RST_KEY_CODE_A;
            set_code_b     = RST_KEY_CODE_B;
            set_hold       = RST_HOLD_TICKS;
            set_active_low = RST_ACTIVE_LOW;
            set_line_valid = RST_LINE_VALID;
            keys_held      = '0;
            hold_left      = '0;
            hold_running   = 1'b0;
            reset_fired    = 1'b0;
            combo_status_q.delete();
        end else begin
            // Register writes.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ENABLE:     set_enable     = i_cfg_data[0];
                    CFG_KEY_CODE_A: set_code_a     = i_cfg_data[KEY_CODE_W-1:0];
                    CFG_KEY_CODE_B: set_code_b     = i_cfg_data[KEY_CODE_W-1:0];
                    CFG_HOLD_TICKS: set_hold       = i_cfg_data[HOLD_W-1:0];
                    CFG_ACTIVE_LOW: set_active_low = i_cfg_data[LINE_W-1:0];
                    CFG_LINE_VALID: set_line_valid = i_cfg_data[LINE_W-1:0];
                    default: ;
                endcase
            end

            // Result words are matched against the oldest prediction.
            if (i_out_valid && !i_out_stall) begin
                got = i_out_word;
                if (combo_status_q.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10) begin
                        $display("%0t: result word %h arrived with nothing outstanding",
                                 $realtime, got);
                    end
                end else begin
                    want = combo_status_q.pop_front();
                    if (got.handled !== want.handled)
                        flag_field("handled", int'(want.handled), int'(got.handled));
                    if (got.held_mask !== want.held_mask)
                        flag_field("held_mask", int'(want.held_mask), int'(got.held_mask));
                    if (got.countdown_running !== want.countdown_running)
                        flag_field("countdown_running", int'(want.countdown_running),
                                   int'(got.countdown_running));
                    if (got.expiry_status !== want.expiry_status)
                        flag_field("expiry_status", int'(want.expiry_status),
                                   int'(got.expiry_status));
                    if (got.reset_occurred !== want.reset_occurred)
                        flag_field("reset_occurred", int'(want.reset_occurred),
                                   int'(got.reset_occurred));
                end
            end

            // Each accepted input word predicts exactly one result word.
            if (i_in_valid && !i_in_stall) begin
                combo_status_q.push_back(advance_combo(i_in_word));
            end
        end
        status_left = combo_status_q.size();
    end

    initial begin
        fail_total  = 0;
        status_left = 0;
    end

endmodule

// ----- tb/key_combo_hold_reset_test.sv -----
module key_combo_hold_reset_test;
    import kchr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid;
    t_in_word              in_word;
    logic                  in_stall;
    logic                  out_valid;
    t_out_word             out_word;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int idle_pct = 14;
    int useful;
    int phase;

    logic in_taken  = 1'b0;
    logic cfg_taken = 1'b0;

    // Settings currently loaded, used to shape the key sequences.
    logic                  cur_en;
    logic [KEY_CODE_W-1:0] cur_a;
    logic [KEY_CODE_W-1:0] cur_b;
    logic [HOLD_W-1:0]     cur_hold;
    logic [LINE_W-1:0]     cur_alow;

    key_combo_hold_reset dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_word   (in_word),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_word  (out_word),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    key_combo_hold_reset_check checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Handshake outcomes, captured at the rising edge and read at the falling edge.
    always @(posedge i_clk) begin
        in_taken  <= in_valid && !in_stall;
        cfg_taken <= cfg_valid && cfg_ready;
    end

    // The result side stalls at random.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // Offers one input word after a random gap and holds it until it is taken.
    task automatic send_item(input t_in_word w);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(negedge i_clk); while (!in_taken);
        useful++;
    endtask

    task automatic send_key(input logic [KEY_CODE_W-1:0] code, input logic down,
                            input logic [LINE_W-1:0] levels);
        t_in_word w;
        w.kind        = KIND_KEY;
        w.event_key   = code;
        w.key_down    = down;
        w.line_levels = levels;
        send_item(w);
    endtask

    task automatic send_tick(input logic [LINE_W-1:0] levels);
        t_in_word w;
        w.kind        = KIND_TICK;
        w.event_key   = 10'($urandom_range(1023));
        w.key_down    = 1'($urandom_range(1));
        w.line_levels = levels;
        send_item(w);
    endtask

    // Holds the sender back until every result word has come out.
    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(negedge i_clk); while (!cfg_taken);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic en, input logic [KEY_CODE_W-1:0] a,
                              input logic [KEY_CODE_W-1:0] b, input logic [HOLD_W-1:0] hold,
                              input logic [LINE_W-1:0] alow, input logic [LINE_W-1:0] lvalid);
        write_reg(CFG_ENABLE, CFG_DATA_W'(en));
        write_reg(CFG_KEY_CODE_A, CFG_DATA_W'(a));
        write_reg(CFG_KEY_CODE_B, CFG_DATA_W'(b));
        write_reg(CFG_HOLD_TICKS, CFG_DATA_W'(hold));
        write_reg(CFG_ACTIVE_LOW, CFG_DATA_W'(alow));
        write_reg(CFG_LINE_VALID, CFG_DATA_W'(lvalid));
        cur_en   = en;
        cur_a    = a;
        cur_b    = b;
        cur_hold = hold;
        cur_alow = alow;
    endtask

    // Presses both keys, lets the hold time run with occasional key traffic, then
    // often releases the keys again.
    task automatic hold_sequence();
        logic [KEY_CODE_W-1:0] first_key;
        logic [KEY_CODE_W-1:0] second_key;
        logic [LINE_W-1:0]     held_levels;
        int                    n_ticks;
        first_key   = $urandom_range(1) ? cur_b : cur_a;
        second_key  = (first_key == cur_a) ? cur_b : cur_a;
        held_levels = ~cur_alow;
        send_key(first_key, 1'b1, 2'($urandom_range(3)));
        if ($urandom_range(4) == 0) begin
            send_key(first_key, 1'b0, 2'($urandom_range(3)));
            send_key(first_key, 1'b1, 2'($urandom_range(3)));
        end
        send_key(second_key, 1'b1, 2'($urandom_range(3)));
        n_ticks = (cur_hold == '0) ? 1 : int'(cur_hold);
        if (n_ticks > 12) begin
            n_ticks = $urandom_range(1, 12);
        end else begin
            n_ticks = n_ticks + $urandom_range(0, 2);
        end
        for (int i = 0; i < n_ticks; i++) begin
            if ($urandom_range(9) == 0) begin
                send_key($urandom_range(1) ? cur_a : cur_b, 1'($urandom_range(1)),
                         2'($urandom_range(3)));
            end else begin
                send_tick(($urandom_range(3) != 0) ? held_levels : 2'($urandom_range(3)));
            end
        end
        if ($urandom_range(1)) begin
            send_key(second_key, 1'b0, 2'($urandom_range(3)));
            send_key(first_key, 1'b0, 2'($urandom_range(3)));
        end
    endtask

    // Stimulus.
    initial begin
        t_in_word              w;
        logic [KEY_CODE_W-1:0] a;
        logic [HOLD_W-1:0]     hold;
        int                    spins;

        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        useful    = 0;
        cur_en    = RST_ENABLE;
        cur_a     = RST_KEY_CODE_A;
        cur_b     = RST_KEY_CODE_B;
        cur_hold  = RST_HOLD_TICKS;
        cur_alow  = RST_ACTIVE_LOW;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: idle tick, unmatched key, partial and full holds, then a stop.
        send_tick(2'b11);
        send_key(10'd0, 1'b1, 2'b00);
        send_key(RST_KEY_CODE_A, 1'b1, 2'b01);
        send_key(RST_KEY_CODE_A, 1'b0, 2'b10);
        send_key(RST_KEY_CODE_B, 1'b1, 2'b11);
        send_key(RST_KEY_CODE_A, 1'b1, 2'b00);
        send_tick(2'b11);
        send_key(RST_KEY_CODE_B, 1'b0, 2'b11);
        send_tick(2'b11);

        // Zero hold time expires on the first tick; a re-press restarts it.
        drain();
        set_config(1'b1, 10'd0, 10'h3FF, 24'd0, 2'b00, 2'b11);
        send_key(10'd0, 1'b1, 2'b00);
        send_key(10'h3FF, 1'b1, 2'b00);
        send_tick(2'b11);
        send_key(10'h3FF, 1'b1, 2'b11);
        send_tick(2'b00);

        // Detection off: key events are ignored.
        drain();
        set_config(1'b0, 10'd0, 10'h3FF, 24'd1, 2'b00, 2'b11);
        send_key(10'd0, 1'b1, 2'b11);
        send_tick(2'b11);

        // Equal key codes move both bits; a missing line never reads as pressed.
        drain();
        set_config(1'b1, 10'h3FF, 10'h3FF, 24'd1, 2'b11, 2'b01);
        send_key(10'h3FF, 1'b0, 2'b00);
        send_key(10'h3FF, 1'b1, 2'b00);
        send_tick(2'b00);

        // Active-low lines with both lines present.
        drain();
        set_config(1'b1, 10'h3FF, 10'h3FF, 24'd1, 2'b11, 2'b11);
        send_key(10'h3FF, 1'b1, 2'b00);
        send_tick(2'b00);
        send_key(10'h3FF, 1'b1, 2'b11);
        send_tick(2'b11);

        // Random phases, each under fresh settings loaded while the block is idle.
        useful = 0;
        phase  = 0;
        while (useful < 600) begin
            drain();
            idle_pct = (phase == 2) ? 0 : 14;
            a = 10'($urandom_range(1023));
            case ($urandom_range(9))
                0: hold = 24'd0;
                1: hold = 24'd6000;
                default: hold = 24'($urandom_range(1, 6));
            endcase
            if (phase == 1) hold = 24'hFFFFFF;
            set_config(($urandom_range(7) != 0), a,
                       ($urandom_range(5) == 0) ? a : 10'($urandom_range(1023)), hold,
                       2'($urandom_range(3)),
                       ($urandom_range(2) == 0) ? 2'($urandom_range(3)) : 2'b11);
            for (int k = 0; k < 6; k++) begin
                if ($urandom_range(4) == 0) begin
                    repeat ($urandom_range(1, 4)) begin
                        w = t_in_word'($urandom);
                        send_item(w);
                    end
                end else begin
                    hold_sequence();
                end
            end
            phase++;
        end

        // Wind down: wait for the last result words, then a little longer for strays.
        in_valid <= 1'b0;
        spins = 0;
        while (pending != 0 && spins < 2000) begin
            @(negedge i_clk);
            spins++;
        end
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("key_combo_hold_reset regression: pass");
        end else begin
            $display("key_combo_hold_reset regression: fail");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #4ms;
        $display("key_combo_hold_reset regression: fail");
        $finish;
    end

endmodule
